FILE: rtl/wid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wid_pkg
// Shared types and constants of the work index distributor: register map,
// mode and status codes, the configuration bundle, the job word passed from
// front to back and the result word.
// ----------------------------------------------------------------------------
package wid_pkg;

  // field widths
  localparam int FIRST_W = 16;
  localparam int TOTAL_W = 13;
  localparam int EC_W    = 9;
  localparam int MAXL_W  = 7;
  localparam int MODE_W  = 2;
  localparam int PE_W    = 8;
  localparam int IDX_W   = 17;
  localparam int POS_W   = 6;
  localparam int STAT_W  = 2;
  localparam int K_W     = 14;
  localparam int STEP_W  = 10;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 16;

  // register indexes
  localparam logic [ADDR_W-1:0] REG_FIRST_INDEX   = 3'd0;
  localparam logic [ADDR_W-1:0] REG_TOTAL_COUNT   = 3'd1;
  localparam logic [ADDR_W-1:0] REG_ELEMENT_COUNT = 3'd2;
  localparam logic [ADDR_W-1:0] REG_MAX_LOCAL     = 3'd3;
  localparam logic [ADDR_W-1:0] REG_MODE          = 3'd4;

  // distribution modes
  localparam logic [MODE_W-1:0] MODE_BLOCK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CYCLIC = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SNAKE  = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_NONE  = 2'd1;
  localparam logic [STAT_W-1:0] ST_TRUNC = 2'd2;
  localparam logic [STAT_W-1:0] ST_BAD   = 2'd3;

  typedef struct packed {
    logic [FIRST_W-1:0] first_index;
    logic [TOTAL_W-1:0] total_count;
    logic [EC_W-1:0]    element_count;
    logic [MAXL_W-1:0]  max_local;
    logic [MODE_W-1:0]  mode;
  } cfg_t;

  typedef enum logic {
    JOB_BAD = 1'b0,
    JOB_RUN = 1'b1
  } job_kind_t;

  // One job: index = base +/- k, k walks from k0 with alternating steps
  // while k < lim.
  typedef struct packed {
    job_kind_t         kind;
    logic              dir_down;
    logic [IDX_W-1:0]  base;
    logic [K_W-1:0]    k0;
    logic [TOTAL_W-1:0] lim;
    logic [STEP_W-1:0] step_a;
    logic [STEP_W-1:0] step_b;
  } job_t;

  typedef struct packed {
    logic [IDX_W-1:0]  index_value;
    logic [POS_W-1:0]  position;
    logic              last;
    logic [STAT_W-1:0] status;
  } result_t;

endpackage

FILE: rtl/wid_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wid_fifo
// Small register queue with push/full and pop/empty; head word shown
// directly on rdata.
// ----------------------------------------------------------------------------
module wid_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/wid_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wid_div
// Restoring divider, one quotient bit per cycle: total count by element
// count, giving block size and remainder.
// ----------------------------------------------------------------------------
module wid_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [wid_pkg::TOTAL_W-1:0] dividend,
  input  logic [wid_pkg::EC_W-1:0]    divisor,
  output logic                        done,
  output logic [wid_pkg::TOTAL_W-1:0] quo,
  output logic [wid_pkg::EC_W-1:0]    rem
);

  localparam int CNT_W = $clog2(wid_pkg::TOTAL_W + 1);

  logic                      busy;
  logic [CNT_W-1:0]          cnt;
  logic [wid_pkg::EC_W:0]    shifted;
  logic [wid_pkg::EC_W:0]    diff;
  logic                      fits;

  // trial subtract of the divisor from the shifted partial remainder
  assign shifted = {rem, quo[wid_pkg::TOTAL_W-1]};
  assign diff    = shifted - {1'b0, divisor};
  assign fits    = (shifted >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(wid_pkg::TOTAL_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: quotient register doubles as dividend shifter
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[wid_pkg::TOTAL_W-2:0], fits};
      rem <= fits ? diff[wid_pkg::EC_W-1:0] : shifted[wid_pkg::EC_W-1:0];
    end
  end

endmodule

FILE: rtl/wid_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wid_front
// Request front end: takes an element number, checks it, works out block
// sizes in block mode and writes one job word to the job queue.
// ----------------------------------------------------------------------------
module wid_front (
  input  logic                     clk,
  input  logic                     rst,
  input  wid_pkg::cfg_t            cfg,
  input  logic                     push,
  input  logic [wid_pkg::PE_W-1:0] element_id,
  output logic                     full,
  output logic                     job_push,
  output wid_pkg::job_t            job,
  input  logic                     job_full
);

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_MUL,
    F_PUSH
  } fstate_t;

  fstate_t                       state;
  logic [wid_pkg::PE_W-1:0]      pe;
  logic [wid_pkg::TOTAL_W-1:0]   q;
  logic [wid_pkg::EC_W-1:0]      r;
  logic [wid_pkg::TOTAL_W-1:0]   prod;

  logic                          accept;
  logic                          div_start;
  logic                          div_done;
  logic [wid_pkg::TOTAL_W-1:0]   div_quo;
  logic [wid_pkg::EC_W-1:0]      div_rem;
  logic [wid_pkg::PE_W+wid_pkg::TOTAL_W-1:0] prod_full;

  logic [wid_pkg::EC_W-1:0]      pe9;
  logic                          pe_lt_r;
  logic [wid_pkg::TOTAL_W-1:0]   start_ofs;
  logic                          bad;

  assign full      = (state != F_IDLE);
  assign accept    = push && !full;
  assign div_start = accept && (cfg.mode == wid_pkg::MODE_BLOCK);
  assign job_push  = (state == F_PUSH) && !job_full;
  assign prod_full = (wid_pkg::PE_W + wid_pkg::TOTAL_W)'(pe)
                   * (wid_pkg::PE_W + wid_pkg::TOTAL_W)'(q);

  wid_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (cfg.total_count),
    .divisor  (cfg.element_count),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept) begin
            state <= div_start ? F_DIV : F_PUSH;
          end
        end
        F_DIV: begin
          if (div_done) begin
            state <= F_MUL;
          end
        end
        F_MUL: begin
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (!job_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  // request payload and block-size results
  always_ff @(posedge clk) begin
    if (accept) begin
      pe <= element_id;
    end
    if (state == F_DIV && div_done) begin
      q <= div_quo;
      r <= div_rem;
    end
    if (state == F_MUL) begin
      prod <= prod_full[wid_pkg::TOTAL_W-1:0];
    end
  end

  // job word
  assign pe9       = {1'b0, pe};
  assign bad       = (pe9 >= cfg.element_count);
  assign pe_lt_r   = (pe9 < r);
  assign start_ofs = prod + wid_pkg::TOTAL_W'(pe_lt_r ? pe9 : r);

  always_comb begin
    job.kind     = bad ? wid_pkg::JOB_BAD : wid_pkg::JOB_RUN;
    job.dir_down = 1'b0;
    job.base     = wid_pkg::IDX_W'(cfg.first_index);
    job.k0       = wid_pkg::K_W'(pe);
    job.lim      = cfg.total_count;
    job.step_a   = wid_pkg::STEP_W'(cfg.element_count);
    job.step_b   = wid_pkg::STEP_W'(cfg.element_count);
    unique case (cfg.mode)
      wid_pkg::MODE_BLOCK: begin
        job.base   = wid_pkg::IDX_W'(cfg.first_index) + wid_pkg::IDX_W'(start_ofs);
        job.k0     = '0;
        job.lim    = q + wid_pkg::TOTAL_W'(pe_lt_r);
        job.step_a = wid_pkg::STEP_W'(1);
        job.step_b = wid_pkg::STEP_W'(1);
      end
      wid_pkg::MODE_CYCLIC: begin
        job.dir_down = 1'b0;
      end
      wid_pkg::MODE_SNAKE: begin
        // owner pattern 0..n-1,n-1..0: gaps alternate 2n-1-2pe and 2pe+1
        job.dir_down = 1'b1;
        job.base     = wid_pkg::IDX_W'(cfg.first_index)
                     + wid_pkg::IDX_W'(cfg.total_count) - wid_pkg::IDX_W'(1);
        job.step_a   = {cfg.element_count, 1'b0} - {1'b0, pe, 1'b0}
                     - wid_pkg::STEP_W'(1);
        job.step_b   = {1'b0, pe, 1'b1};
      end
      default: begin
        // unused mode assigns nothing
        job.lim = '0;
      end
    endcase
  end

endmodule

FILE: rtl/wid_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wid_back
// Result back end: walks one job word, one result per cycle unless res_full,
// applying the per-element limit and closing with the right status.
// ----------------------------------------------------------------------------
module wid_back #(
  parameter int MAX_PER_ELEMENT = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [wid_pkg::MAXL_W-1:0] max_local,
  input  logic                       job_valid,
  input  wid_pkg::job_t              job,
  output logic                       job_pop,
  output logic                       res_push,
  output wid_pkg::result_t           res,
  input  logic                       res_full
);

  localparam logic [wid_pkg::MAXL_W-1:0] MAX_L    = wid_pkg::MAXL_W'(MAX_PER_ELEMENT);
  localparam logic [wid_pkg::POS_W-1:0]  LAST_POS = wid_pkg::POS_W'(MAX_PER_ELEMENT - 1);

  typedef enum logic {
    B_IDLE,
    B_RUN
  } bstate_t;

  bstate_t                       state;
  wid_pkg::job_kind_t            kind;
  logic                          dir_down;
  logic [wid_pkg::IDX_W-1:0]     base;
  logic [wid_pkg::K_W-1:0]       k;
  logic [wid_pkg::TOTAL_W-1:0]   lim;
  logic [wid_pkg::STEP_W-1:0]    step_a;
  logic [wid_pkg::STEP_W-1:0]    step_b;
  logic                          alt;
  logic [wid_pkg::POS_W-1:0]     j;

  logic [wid_pkg::MAXL_W-1:0]    limit;
  logic [wid_pkg::K_W-1:0]       k_next;
  logic                          cand;
  logic                          more;
  logic                          fin;
  logic                          adv;

  assign job_pop  = (state == B_IDLE) && job_valid;
  assign res_push = (state == B_RUN) && !res_full;

  // next candidate and end tests
  assign limit  = (max_local > MAX_L) ? MAX_L : max_local;
  assign k_next = k + wid_pkg::K_W'(alt ? step_b : step_a);
  assign cand   = (k < wid_pkg::K_W'(lim));
  assign more   = (k_next < wid_pkg::K_W'(lim));

  // result word for the current step
  always_comb begin
    res.index_value = '0;
    res.position    = j;
    res.last        = 1'b1;
    res.status      = wid_pkg::ST_OK;
    fin             = 1'b1;
    adv             = 1'b0;
    priority if (kind == wid_pkg::JOB_BAD) begin
      res.position = '0;
      res.status   = wid_pkg::ST_BAD;
    end else if (!cand) begin
      res.position = '0;
      res.status   = wid_pkg::ST_NONE;
    end else if (wid_pkg::MAXL_W'(j) == limit || (j == LAST_POS && more)) begin
      res.status = wid_pkg::ST_TRUNC;
    end else begin
      res.index_value = dir_down ? base - wid_pkg::IDX_W'(k) : base + wid_pkg::IDX_W'(k);
      res.last        = !more;
      fin             = !more;
      adv             = 1'b1;
    end
  end

  // sequencer and walk registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      unique case (state)
        B_IDLE: begin
          if (job_valid) begin
            state <= B_RUN;
          end
        end
        B_RUN: begin
          if (!res_full && fin) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      kind     <= job.kind;
      dir_down <= job.dir_down;
      base     <= job.base;
      k        <= job.k0;
      lim      <= job.lim;
      step_a   <= job.step_a;
      step_b   <= job.step_b;
      alt      <= 1'b0;
      j        <= '0;
    end else if (res_push && adv) begin
      k   <= k_next;
      alt <= ~alt;
      j   <= j + 1'b1;
    end
  end

endmodule

FILE: rtl/work_index_distributor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// work_index_distributor
// Emits the work indices assigned to one processing element out of the
// configured range, in block, round robin or snake order.
// ----------------------------------------------------------------------------
//  channel   ports                                        word accepted when
//  request   push, full, element_id                       push && !full
//  result    pop, empty, index_value, position, last,     pop && !empty
//            status
//  config    cfg_we, cfg_addr, cfg_data                   cfg_we
//
// The back end emits one result per cycle while the result queue has room.
// In block mode the front end runs the bit-serial division of total_count by
// element_count, takes its result and forms the block start product, then
// writes the job word, taking no new request meanwhile. It overlaps with the
// back end through the job queue. Reset restores sequencers and settings and
// empties both queues. Either side may stall; a full result queue holds the
// back end, a full job queue holds the front end.
// ----------------------------------------------------------------------------
module work_index_distributor #(
  parameter int MAX_PER_ELEMENT = 64,
  parameter int JOB_DEPTH       = 2,
  parameter int RES_DEPTH       = 2
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [wid_pkg::ADDR_W-1:0] cfg_addr,
  input  logic [wid_pkg::DATA_W-1:0] cfg_data,
  input  logic                       push,
  output logic                       full,
  input  logic [wid_pkg::PE_W-1:0]   element_id,
  input  logic                       pop,
  output logic                       empty,
  output logic [wid_pkg::IDX_W-1:0]  index_value,
  output logic [wid_pkg::POS_W-1:0]  position,
  output logic                       last,
  output logic [wid_pkg::STAT_W-1:0] status
);

  wid_pkg::cfg_t    cfg;
  wid_pkg::job_t    job_in;
  wid_pkg::job_t    job_out;
  wid_pkg::result_t res_in;
  wid_pkg::result_t res_out;

  logic [$bits(wid_pkg::job_t)-1:0]    job_in_w;
  logic [$bits(wid_pkg::job_t)-1:0]    job_out_w;
  logic [$bits(wid_pkg::result_t)-1:0] res_in_w;
  logic [$bits(wid_pkg::result_t)-1:0] res_out_w;

  logic job_push;
  logic job_full;
  logic job_empty;
  logic job_pop;
  logic res_push;
  logic res_full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_index   <= wid_pkg::FIRST_W'(1);
      cfg.total_count   <= wid_pkg::TOTAL_W'(1);
      cfg.element_count <= wid_pkg::EC_W'(1);
      cfg.max_local     <= wid_pkg::MAXL_W'(64);
      cfg.mode          <= wid_pkg::MODE_BLOCK;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        wid_pkg::REG_FIRST_INDEX:   cfg.first_index   <= cfg_data;
        wid_pkg::REG_TOTAL_COUNT:   cfg.total_count   <= cfg_data[wid_pkg::TOTAL_W-1:0];
        wid_pkg::REG_ELEMENT_COUNT: cfg.element_count <= cfg_data[wid_pkg::EC_W-1:0];
        wid_pkg::REG_MAX_LOCAL:     cfg.max_local     <= cfg_data[wid_pkg::MAXL_W-1:0];
        wid_pkg::REG_MODE:          cfg.mode          <= cfg_data[wid_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // front end
  wid_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .push       (push),
    .element_id (element_id),
    .full       (full),
    .job_push   (job_push),
    .job        (job_in),
    .job_full   (job_full)
  );

  // job queue between front and back
  assign job_in_w = job_in;
  assign job_out  = wid_pkg::job_t'(job_out_w);

  wid_fifo #(
    .WIDTH ($bits(wid_pkg::job_t)),
    .DEPTH (JOB_DEPTH)
  ) u_job_q (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .wdata (job_in_w),
    .full  (job_full),
    .pop   (job_pop),
    .rdata (job_out_w),
    .empty (job_empty)
  );

  // back end
  wid_back #(
    .MAX_PER_ELEMENT (MAX_PER_ELEMENT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .max_local (cfg.max_local),
    .job_valid (!job_empty),
    .job       (job_out),
    .job_pop   (job_pop),
    .res_push  (res_push),
    .res       (res_in),
    .res_full  (res_full)
  );

  // result queue
  assign res_in_w = res_in;
  assign res_out  = wid_pkg::result_t'(res_out_w);

  wid_fifo #(
    .WIDTH ($bits(wid_pkg::result_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in_w),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out_w),
    .empty (empty)
  );

  assign index_value = res_out.index_value;
  assign position    = res_out.position;
  assign last        = res_out.last;
  assign status      = res_out.status;

endmodule

FILE: dv/work_index_distributor_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// work_index_distributor_test
// Self-checking bench for the work index distributor. Request words carry an
// element number; each accepted word is expanded by a behavioral predictor
// into the list of result words (index, position, last, status) for the
// current register settings. Result words are checked in order, field by
// field. A directed set of settings covers all modes, range extremes,
// truncation, empty assignments and bad element numbers; random settings and
// requests follow, with bursty pushes and a patterned pop.
// ----------------------------------------------------------------------------
module work_index_distributor_test;
  import wid_pkg::*;

  localparam int MAX_PER_ELEMENT = 64;
  localparam int RANDOM_ITEMS    = 410;
  localparam int DRAIN_CYCLES    = 40;
  localparam int STALL_LIMIT     = 1000;
  // mode encoding with no distribution behind it
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [ADDR_W-1:0]  cfg_addr = '0;
  logic [DATA_W-1:0]  cfg_data = '0;
  logic               push = 1'b0;
  logic               full;
  logic [PE_W-1:0]    element_id = '0;
  logic               pop = 1'b0;
  logic               empty;
  logic [IDX_W-1:0]   index_value;
  logic [POS_W-1:0]   position;
  logic               last;
  logic [STAT_W-1:0]  status;

  logic [PE_W-1:0]    pending_ids[$];
  result_t            expected_words[$];
  cfg_t               shadow_cfg;
  int unsigned        mismatch_count = 0;
  int unsigned        idle_cycles = 0;
  int unsigned        burst_left = 0;
  int unsigned        gap_left = 0;
  logic [15:0]        pop_pattern = 16'hFFFF;
  int unsigned        pattern_age = 0;

  work_index_distributor dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_data    (cfg_data),
    .push        (push),
    .full        (full),
    .element_id  (element_id),
    .pop         (pop),
    .empty       (empty),
    .index_value (index_value),
    .position    (position),
    .last        (last),
    .status      (status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic cfg_t make_cfg(int unsigned fi, int unsigned tc, int unsigned ec,
                                    int unsigned ml, logic [MODE_W-1:0] md);
    cfg_t c;
    c.first_index   = FIRST_W'(fi);
    c.total_count   = TOTAL_W'(tc);
    c.element_count = EC_W'(ec);
    c.max_local     = MAXL_W'(ml);
    c.mode          = md;
    return c;
  endfunction

  function automatic void add_word(int unsigned idx, int unsigned pos, logic lst,
                                   logic [STAT_W-1:0] st);
    result_t w;
    w.index_value = IDX_W'(idx);
    w.position    = POS_W'(pos);
    w.last        = lst;
    w.status      = st;
    expected_words.push_back(w);
  endfunction

  // Expand one request into the result words the block owes for it
  function automatic void predict_indices(input logic [PE_W-1:0] pe);
    int unsigned fi, tc, ec, ml, lim, quo, rem, start, cnt, kept, emit, per, m, owner;
    int unsigned idx_list[MAX_PER_ELEMENT];
    fi   = shadow_cfg.first_index;
    tc   = shadow_cfg.total_count;
    ec   = shadow_cfg.element_count;
    ml   = shadow_cfg.max_local;
    cnt  = 0;
    kept = 0;
    // element number check wins over everything else
    if (pe >= ec) begin
      add_word(0, 0, 1'b1, ST_BAD);
      return;
    end
    lim = (ml > MAX_PER_ELEMENT) ? MAX_PER_ELEMENT : ml;
    case (shadow_cfg.mode)
      MODE_BLOCK: begin
        quo   = tc / ec;
        rem   = tc % ec;
        start = pe * quo + ((pe < rem) ? pe : rem);
        cnt   = quo + ((pe < rem) ? 1 : 0);
        for (int unsigned k = 0; k < cnt && kept < MAX_PER_ELEMENT; k++) begin
          idx_list[kept] = fi + start + k;
          kept++;
        end
      end
      MODE_CYCLIC: begin
        for (int unsigned k = 0; k < tc; k++) begin
          if (k % ec == pe) begin
            if (kept < MAX_PER_ELEMENT) begin
              idx_list[kept] = fi + k;
              kept++;
            end
            cnt++;
          end
        end
      end
      MODE_SNAKE: begin
        // owners run 0..n-1 then n-1..0, indices dealt from the top
        per = 2 * ec;
        for (int unsigned k = 0; k < tc; k++) begin
          m     = k % per;
          owner = (m < ec) ? m : per - 1 - m;
          if (owner == pe) begin
            if (kept < MAX_PER_ELEMENT) begin
              idx_list[kept] = fi + tc - 1 - k;
              kept++;
            end
            cnt++;
          end
        end
      end
      default: ;
    endcase
    if (cnt == 0) begin
      add_word(0, 0, 1'b1, ST_NONE);
    end else if (cnt > lim) begin
      emit = (lim < MAX_PER_ELEMENT - 1) ? lim : MAX_PER_ELEMENT - 1;
      for (int unsigned k = 0; k < emit; k++) begin
        add_word(idx_list[k], k, 1'b0, ST_OK);
      end
      add_word(0, emit, 1'b1, ST_TRUNC);
    end else begin
      for (int unsigned k = 0; k < cnt; k++) begin
        add_word(idx_list[k], k, (k + 1 == cnt), ST_OK);
      end
    end
  endfunction

  task automatic note_mismatch(string field, logic [31:0] exp_v, logic [31:0] act_v);
    mismatch_count++;
    $display("%0t: %s expected %0d, got %0d", $time, field, exp_v, act_v);
  endtask

  // Block is idle once no request is waiting and every result word is in
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_ids.size() != 0 || push || expected_words.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= data;
  endtask

  task automatic apply_config(cfg_t c);
    wait_idle();
    write_reg(REG_FIRST_INDEX,   DATA_W'(c.first_index));
    write_reg(REG_TOTAL_COUNT,   DATA_W'(c.total_count));
    write_reg(REG_ELEMENT_COUNT, DATA_W'(c.element_count));
    write_reg(REG_MAX_LOCAL,     DATA_W'(c.max_local));
    write_reg(REG_MODE,          DATA_W'(c.mode));
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_cfg = c;
  endtask

  // Request driver: bursts of pushes separated by random gaps
  always @(posedge clk) begin
    logic nxt_push;
    if (rst) begin
      push <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else if (!push || !full) begin
      nxt_push = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_ids.size() > 0) begin
        nxt_push = 1'b1;
        element_id <= pending_ids.pop_front();
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 8);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      push <= nxt_push;
    end
  end

  // Result receiver: pop follows a rotating pattern, re-drawn now and then
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      pattern_age = 0;
    end else begin
      if (pattern_age == 0) begin
        pattern_age = $urandom_range(16, 128);
        if ($urandom_range(0, 3) == 0) pop_pattern = 16'hFFFF;
        else pop_pattern = 16'($urandom());
        if (pop_pattern == 16'h0000) pop_pattern = 16'h0001;
      end
      pop <= pop_pattern[0];
      pop_pattern = {pop_pattern[0], pop_pattern[15:1]};
      pattern_age--;
    end
  end

  // Monitor: predict on accepted requests, check accepted result words
  always @(posedge clk) begin
    result_t w;
    if (!rst) begin
      if (push && !full) predict_indices(element_id);
      if (pop && !empty) begin
        if (expected_words.size() == 0) begin
          mismatch_count++;
          $display("%0t: result word expected none, got index %0d status %0d",
                   $time, index_value, status);
        end else begin
          w = expected_words.pop_front();
          if (index_value !== w.index_value) note_mismatch("index_value", w.index_value, index_value);
          if (position !== w.position) note_mismatch("position", w.position, position);
          if (last !== w.last) note_mismatch("last", w.last, last);
          if (status !== w.status) note_mismatch("status", w.status, status);
        end
      end
    end
  end

  // Watchdog on cycles with no handshake of any kind
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("work_index_distributor: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    cfg_t        c;
    int unsigned n, random_sent, r, cap;
    shadow_cfg = make_cfg(1, 1, 1, 64, MODE_BLOCK);
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset settings: one element owning one index
    pending_ids.push_back(8'd0);
    pending_ids.push_back(8'd1);
    pending_ids.push_back(8'd255);

    // top of the index range, all 256 elements
    apply_config(make_cfg(65535, 4096, 256, 64, MODE_BLOCK));
    pending_ids.push_back(8'd0);
    pending_ids.push_back(8'd255);

    // blocks with a remainder, range starting at zero
    apply_config(make_cfg(0, 10, 4, 64, MODE_BLOCK));
    for (int i = 0; i < 4; i++) pending_ids.push_back(PE_W'(i));

    // round robin: exactly the limit, then three past it
    apply_config(make_cfg(100, 192, 3, 64, MODE_CYCLIC));
    pending_ids.push_back(8'd2);
    apply_config(make_cfg(100, 200, 3, 64, MODE_CYCLIC));
    pending_ids.push_back(8'd0);

    // snake: one element at the limit, two cut short
    apply_config(make_cfg(5, 11, 3, 3, MODE_SNAKE));
    for (int i = 0; i < 3; i++) pending_ids.push_back(PE_W'(i));

    // zero limit: only the truncation word
    apply_config(make_cfg(5, 11, 3, 0, MODE_SNAKE));
    pending_ids.push_back(8'd1);

    // limit above the per-element maximum saturates
    apply_config(make_cfg(1, 4096, 1, 100, MODE_CYCLIC));
    pending_ids.push_back(8'd0);

    // empty range
    apply_config(make_cfg(1, 0, 4, 64, MODE_BLOCK));
    pending_ids.push_back(8'd1);

    // no elements: every number is bad
    apply_config(make_cfg(1, 10, 0, 64, MODE_BLOCK));
    pending_ids.push_back(8'd0);

    // unused mode assigns nothing
    apply_config(make_cfg(1, 100, 2, 64, MODE_UNUSED));
    pending_ids.push_back(8'd0);

    // more elements than indices
    apply_config(make_cfg(7, 2, 5, 64, MODE_BLOCK));
    pending_ids.push_back(8'd1);
    pending_ids.push_back(8'd3);
    pending_ids.push_back(8'd4);

    // index zero handed out
    apply_config(make_cfg(0, 3, 2, 64, MODE_CYCLIC));
    pending_ids.push_back(8'd0);

    // random settings, mostly small ranges and element counts
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 9);
      c.first_index = (r == 0) ? '0 : (r == 1) ? 16'hFFFF : FIRST_W'($urandom_range(1, 65535));
      r = $urandom_range(0, 19);
      c.total_count = (r == 0) ? '0 :
                      (r == 1) ? TOTAL_W'($urandom_range(4097, 8191)) :
                      (r <= 4) ? TOTAL_W'($urandom_range(1, 4096)) :
                                 TOTAL_W'($urandom_range(1, 300));
      r = $urandom_range(0, 39);
      c.element_count = (r == 0) ? '0 :
                        (r == 1) ? EC_W'($urandom_range(257, 511)) :
                        (r <= 8) ? EC_W'($urandom_range(1, 256)) :
                                   EC_W'($urandom_range(1, 16));
      r = $urandom_range(0, 9);
      c.max_local = (r == 0) ? MAXL_W'($urandom_range(65, 127)) :
                    (r == 1) ? '0 : MAXL_W'($urandom_range(1, 64));
      c.mode = ($urandom_range(0, 11) == 0) ? MODE_UNUSED : MODE_W'($urandom_range(0, 2));
      apply_config(c);
      cap = (c.element_count == 0 || c.element_count > 256) ? 256 : c.element_count;
      n = $urandom_range(4, 16);
      repeat (n) begin
        if ($urandom_range(0, 9) < 8) pending_ids.push_back(PE_W'($urandom_range(0, cap - 1)));
        else pending_ids.push_back(PE_W'($urandom_range(0, 255)));
      end
      random_sent += n;
    end

    wait_idle();
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("work_index_distributor: match");
    end else begin
      $display("work_index_distributor: mismatch");
    end
    $finish;
  end

endmodule
